[src/tsr_pkg.sv]
package tsr_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int INDEX_W = 32;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_SEG  = 2'd0;
    localparam logic [OP_W-1:0] OP_END  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // commands from the sequencer to the slot store
    typedef struct packed {
        logic wr;
        logic rd;
        logic clr;
    } store_ctrl_t;

endpackage

[src/tsr_store.sv]
module tsr_store #(
    parameter int  CAPACITY = tsr_pkg::CAPACITY_DEF,
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tsr_pkg::store_ctrl_t       ctrl,
    input  logic [SLOT_W-1:0]          wr_slot,
    input  logic [tsr_pkg::BYTE_W-1:0] wr_data,
    input  logic [SLOT_W-1:0]          rd_slot,
    output logic [tsr_pkg::BYTE_W-1:0] rd_data,
    output logic [CAPACITY-1:0]        valid
);

    logic [tsr_pkg::BYTE_W-1:0] mem [CAPACITY];
    logic [tsr_pkg::BYTE_W-1:0] rd_data_reg;
    logic [CAPACITY-1:0]        valid_reg;
    logic [CAPACITY-1:0]        valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clr)
        begin
            valid_next = '0;
        end
        else
        begin
            if (ctrl.wr)
            begin
                valid_next[wr_slot] = 1'b1;
            end
            // a read takes the byte out of the ring
            if (ctrl.rd)
            begin
                valid_next[rd_slot] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            mem[wr_slot] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

[src/tcp_stream_reassembler.sv]
// a request with no in-order byte passes calc, place for an open-stream segment, then status, which
// loads its single result; a byte at the assembled position is loaded in drain, then each stored
// byte that follows without a gap is read out in turn, paced by the single store read port
// throughput: one request at a time; the next request is taken after the last result is loaded
// reset: valid bits, positions, counters and flags clear at once; the byte store is not cleared
module tcp_stream_reassembler #(
    parameter int CAPACITY = tsr_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seg_valid,
    output logic                        seg_stall,
    input  logic [tsr_pkg::OP_W-1:0]    op,
    input  logic [tsr_pkg::INDEX_W-1:0] index,
    input  logic [tsr_pkg::BYTE_W-1:0]  data_byte,
    input  logic [tsr_pkg::COUNT_W-1:0] read_count,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        byte_valid,
    output logic [tsr_pkg::BYTE_W-1:0]  out_byte,
    output logic                        last_of_run,
    output logic                        stream_ended,
    output logic [tsr_pkg::COUNT_W-1:0] unassembled_count,
    output logic [tsr_pkg::INDEX_W-1:0] assembled_total
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IW     = tsr_pkg::INDEX_W;
    localparam int BW     = tsr_pkg::BYTE_W;
    localparam int CW     = tsr_pkg::COUNT_W;
    localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [SLOT_W:0]   CAP_SUM  = (SLOT_W + 1)'(CAPACITY);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CALC   = 5'b00010,
        S_PLACE  = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_STATUS = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [tsr_pkg::OP_W-1:0] op_reg;
    logic [IW-1:0]            idx_reg;
    logic [BW-1:0]            db_reg;
    logic [CW-1:0]            rc_reg;

    logic [IW-1:0]     ap_reg, ap_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  unread_reg, unread_next;
    logic              end_known_reg, end_known_next;
    logic [IW-1:0]     ep_reg, ep_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic              fin_reg, fin_next;
    logic [IW-1:0]     off_reg, off_next;
    logic [IW-1:0]     eoff_reg, eoff_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              from_mem_reg, from_mem_next;

    logic          res_valid_reg, res_valid_next;
    logic          bv_reg, bv_next;
    logic [BW-1:0] ob_reg, ob_next;
    logic          last_reg, last_next;
    logic          ended_reg, ended_next;
    logic [CW-1:0] held_out_reg, held_out_next;
    logic [IW-1:0] total_reg, total_next;
    logic          res_load;

    tsr_pkg::store_ctrl_t st_ctrl;
    logic [SLOT_W-1:0]    place_slot;
    logic [BW-1:0]        rd_data;
    logic [CAPACITY-1:0]  slot_valid;

    logic              out_ok;
    logic              accept;
    logic [CNT_W-1:0]  window;
    logic              hit;
    logic [SLOT_W:0]   slot_sum;
    logic              at_end;
    logic              cont;
    logic [CW-1:0]     unread_w;
    logic [CW-1:0]     read_dec;
    logic [BW-1:0]     cur_byte;

    tsr_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (st_ctrl),
        .wr_slot (place_slot),
        .wr_data (db_reg),
        .rd_slot (head_reg),
        .rd_data (rd_data),
        .valid   (slot_valid)
    );

    assign out_ok    = !res_valid_reg || !res_stall;
    assign seg_stall = (state_reg != S_IDLE);
    assign accept    = seg_valid && !seg_stall;

    assign window = CAP_CNT - unread_reg;
    assign hit    = (off_reg < {{(IW - CNT_W){1'b0}}, window})
                    && (!end_known_reg || (off_reg < eoff_reg));

    // ring slot of the byte: head plus offset, folded once
    always_comb
    begin
        slot_sum = {1'b0, head_reg} + {1'b0, off_reg[SLOT_W-1:0]};
        if (slot_sum >= CAP_SUM)
        begin
            slot_sum = slot_sum - CAP_SUM;
        end
    end
    assign place_slot = slot_sum[SLOT_W-1:0];

    assign at_end   = end_known_reg && (ap_reg == ep_reg);
    assign cont     = slot_valid[head_reg] && !at_end && (n_reg < CAP_CNT);
    assign cur_byte = from_mem_reg ? rd_data : db_reg;

    assign unread_w = CW'(unread_reg);
    assign read_dec = (rc_reg < unread_w) ? rc_reg : unread_w;

    always_comb
    begin
        state_next     = state_reg;
        ap_next        = ap_reg;
        head_next      = head_reg;
        unread_next    = unread_reg;
        end_known_next = end_known_reg;
        ep_next        = ep_reg;
        held_next      = held_reg;
        fin_next       = fin_reg;
        off_next       = off_reg;
        eoff_next      = eoff_reg;
        n_next         = n_reg;
        from_mem_next  = from_mem_reg;
        st_ctrl        = '0;
        res_load       = 1'b0;
        bv_next        = bv_reg;
        ob_next        = ob_reg;
        last_next      = last_reg;
        ended_next     = ended_reg;
        held_out_next  = held_out_reg;
        total_next     = total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                state_next = S_STATUS;
                case (op_reg)
                    tsr_pkg::OP_SEG:
                    begin
                        if (!fin_reg)
                        begin
                            off_next   = idx_reg - ap_reg;
                            eoff_next  = ep_reg - ap_reg;
                            state_next = S_PLACE;
                        end
                    end
                    tsr_pkg::OP_END:
                    begin
                        if (!fin_reg)
                        begin
                            end_known_next = 1'b1;
                            ep_next        = idx_reg;
                            if (idx_reg == ap_reg)
                            begin
                                fin_next    = 1'b1;
                                held_next   = '0;
                                st_ctrl.clr = 1'b1;
                            end
                        end
                    end
                    tsr_pkg::OP_READ:
                    begin
                        unread_next = CNT_W'(unread_w - read_dec);
                    end
                    default:
                    begin
                        state_next = S_STATUS;
                    end
                endcase
            end

            S_PLACE:
            begin
                state_next = S_STATUS;
                if (hit)
                begin
                    if (off_reg == '0)
                    begin
                        ap_next       = ap_reg + 1'b1;
                        head_next     = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                        unread_next   = unread_reg + 1'b1;
                        n_next        = CNT_W'(1);
                        from_mem_next = 1'b0;
                        state_next    = S_DRAIN;
                    end
                    else if (!slot_valid[place_slot])
                    begin
                        st_ctrl.wr = 1'b1;
                        held_next  = held_reg + 1'b1;
                    end
                end
            end

            S_DRAIN:
            begin
                if (out_ok)
                begin
                    // result for the byte just passed; its flags look one step ahead
                    res_load      = 1'b1;
                    bv_next       = 1'b1;
                    ob_next       = cur_byte;
                    last_next     = !cont;
                    ended_next    = !cont && at_end;
                    held_out_next = (!cont && at_end) ? '0 : CW'(held_reg);
                    total_next    = ap_reg;
                    if (cont)
                    begin
                        st_ctrl.rd    = 1'b1;
                        held_next     = (held_reg != '0) ? held_reg - 1'b1 : held_reg;
                        ap_next       = ap_reg + 1'b1;
                        head_next     = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                        unread_next   = unread_reg + 1'b1;
                        n_next        = n_reg + 1'b1;
                        from_mem_next = 1'b1;
                    end
                    else
                    begin
                        if (at_end)
                        begin
                            fin_next    = 1'b1;
                            held_next   = '0;
                            st_ctrl.clr = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            S_STATUS:
            begin
                if (out_ok)
                begin
                    res_load      = 1'b1;
                    bv_next       = 1'b0;
                    ob_next       = '0;
                    last_next     = 1'b1;
                    ended_next    = fin_reg;
                    held_out_next = CW'(held_reg);
                    total_next    = ap_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ap_reg        <= '0;
            head_reg      <= '0;
            unread_reg    <= '0;
            end_known_reg <= 1'b0;
            ep_reg        <= '0;
            held_reg      <= '0;
            fin_reg       <= 1'b0;
            n_reg         <= '0;
            from_mem_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ap_reg        <= ap_next;
            head_reg      <= head_next;
            unread_reg    <= unread_next;
            end_known_reg <= end_known_next;
            ep_reg        <= ep_next;
            held_reg      <= held_next;
            fin_reg       <= fin_next;
            n_reg         <= n_next;
            from_mem_reg  <= from_mem_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            idx_reg <= index;
            db_reg  <= data_byte;
            rc_reg  <= read_count;
        end
        off_reg      <= off_next;
        eoff_reg     <= eoff_next;
        bv_reg       <= bv_next;
        ob_reg       <= ob_next;
        last_reg     <= last_next;
        ended_reg    <= ended_next;
        held_out_reg <= held_out_next;
        total_reg    <= total_next;
    end

    assign res_valid         = res_valid_reg;
    assign byte_valid        = bv_reg;
    assign out_byte          = ob_reg;
    assign last_of_run       = last_reg;
    assign stream_ended      = ended_reg;
    assign unassembled_count = held_out_reg;
    assign assembled_total   = total_reg;

endmodule
